[sv/pcm_voice_mixer_macros.svh]
// Assertion helpers for the PCM voice mixer.
// Both expect signals named clk and rst in the module that uses them.
`ifndef PCM_VOICE_MIXER_MACROS_SVH
`define PCM_VOICE_MIXER_MACROS_SVH

// Same-cycle implication
`define PVM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define PVM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/pvm_pkg.sv]
`timescale 1ns / 1ps

package pvm_pkg;

  // Sizes
  localparam int VOICE_COUNT  = 8;
  localparam int SAMPLE_DEPTH = 4096;   // power of two: store addresses wrap by masking
  localparam int STORE_AW     = $clog2(SAMPLE_DEPTH);
  localparam int VIDX_W       = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

  // Field widths
  localparam int OP_W     = 2;
  localparam int ADDR_W   = 12;
  localparam int LEN_W    = 13;
  localparam int SAMPLE_W = 16;
  localparam int LEVEL_W  = 10;
  localparam int SLOT_W   = 3;

  // Mixing
  localparam int MIX_SHIFT = 6;
  localparam int SUM_W     = SAMPLE_W + VIDX_W + 1;
  localparam logic [LEVEL_W-1:0] MIX_OFFSET = LEVEL_W'(10'h200);

  typedef logic [OP_W-1:0]            op_t;
  typedef logic [ADDR_W-1:0]          addr_t;
  typedef logic [LEN_W-1:0]           len_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [LEVEL_W-1:0]         level_t;
  typedef logic [SLOT_W-1:0]          slot_t;

  // Operation codes
  localparam op_t OP_TICK  = 2'd0;
  localparam op_t OP_PLAY  = 2'd1;
  localparam op_t OP_WRITE = 2'd2;

endpackage

[sv/pvm_req_if.sv]
`timescale 1ns / 1ps

// Request channel into the mixer
interface pvm_req_if import pvm_pkg::*;;
  logic    valid;
  logic    ready;
  op_t     operation;
  addr_t   address;
  len_t    length;
  sample_t sample_value;

  modport source (output valid, output operation, output address, output length,
                  output sample_value, input ready);
  modport sink   (input valid, input operation, input address, input length,
                  input sample_value, output ready);
endinterface

[sv/pvm_rsp_if.sv]
`timescale 1ns / 1ps

// Result channel out of the mixer
interface pvm_rsp_if import pvm_pkg::*;;
  logic   valid;
  logic   ready;
  level_t dac_level;
  logic   started;
  slot_t  voice_slot;

  modport source (output valid, output dac_level, output started, output voice_slot,
                  input ready);
  modport sink   (input valid, input dac_level, input started, input voice_slot,
                  output ready);
endinterface

[sv/pcm_voice_mixer.sv]
`timescale 1ns / 1ps
`include "pcm_voice_mixer_macros.svh"

// Eight-voice PCM playback mixer. Every request gives exactly one result. A write stores one
// signed 16-bit sample in the 4096-entry sample store; a play claims the lowest free voice
// (started=1, voice_slot) or is dropped when all voices are busy; a tick mixes one output
// sample, dac_level = ((sum >>> 6) + 512) mod 1024, with no saturation. Write, play and
// unused operation codes load their result into the output register when accepted. A tick's
// voices are visited one per cycle in the scan state through the single read port of the
// sample store and one shared accumulator, then the finish state completes the mix and
// registers the result. The result sits in an output register; a new request is taken once
// the sequencer is idle and that register is empty or being drained. Store entries must be
// written before a playing voice reads them.
module pcm_voice_mixer import pvm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  pvm_req_if.sink  req,
  pvm_rsp_if.source rsp
);

  // Sequencer codes
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0] state;

  // Sample store
  sample_t             store [SAMPLE_DEPTH];
  sample_t             rd_data;
  logic [STORE_AW-1:0] rd_addr;

  // Voice table
  logic  voice_active   [VOICE_COUNT];
  addr_t voice_start    [VOICE_COUNT];
  len_t  voice_length   [VOICE_COUNT];
  len_t  voice_position [VOICE_COUNT];

  // Tick datapath
  logic [VIDX_W-1:0]  vidx;
  logic               acc_pending;
  logic signed [SUM_W-1:0] acc;
  logic signed [SUM_W-1:0] acc_final;
  logic               cur_active;
  logic               cur_expired;
  logic               scan_expire;
  len_t               addr_sum;
  logic               last_voice;

  // Free voice search
  logic              free_found;
  logic [VIDX_W-1:0] free_idx;

  // Output register
  logic   out_valid;
  level_t out_level;
  logic   out_started;
  slot_t  out_slot;

  logic accept;

  // Handshake
  assign req.ready = (state == S_IDLE) && (!out_valid || rsp.ready);
  assign accept    = req.valid && req.ready;

  assign rsp.valid      = out_valid;
  assign rsp.dac_level  = out_level;
  assign rsp.started    = out_started;
  assign rsp.voice_slot = out_slot;

  // Current voice of the scan
  assign cur_active  = voice_active[vidx];
  assign cur_expired = voice_position[vidx] >= voice_length[vidx];
  assign scan_expire = (state == S_SCAN) && cur_active && cur_expired;
  assign addr_sum    = LEN_W'(voice_start[vidx]) + voice_position[vidx];
  assign rd_addr     = addr_sum[STORE_AW-1:0];
  assign last_voice  = (vidx == VIDX_W'(VOICE_COUNT - 1));

  // Final sum folds in the read still in flight
  assign acc_final = acc_pending ? acc + SUM_W'(rd_data) : acc;

  // Lowest free voice
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = VOICE_COUNT - 1; i >= 0; i--) begin
      if (!voice_active[i]) begin
        free_found = 1'b1;
        free_idx   = VIDX_W'(i);
      end
    end
  end

  // Store write port
  always_ff @(posedge clk) begin
    if (accept && req.operation == OP_WRITE) begin
      store[req.address[STORE_AW-1:0]] <= req.sample_value;
    end
  end

  // Store read port, registered
  always_ff @(posedge clk) begin
    rd_data <= store[rd_addr];
  end

  // Sequencer, voice table and accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      vidx        <= '0;
      acc_pending <= 1'b0;
      acc         <= '0;
      for (int i = 0; i < VOICE_COUNT; i++) begin
        voice_active[i]   <= 1'b0;
        voice_start[i]    <= '0;
        voice_length[i]   <= '0;
        voice_position[i] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && req.operation == OP_TICK) begin
            state       <= S_SCAN;
            vidx        <= '0;
            acc         <= '0;
            acc_pending <= 1'b0;
          end
          if (accept && req.operation == OP_PLAY && free_found) begin
            voice_active[free_idx]   <= 1'b1;
            voice_start[free_idx]    <= req.address;
            voice_length[free_idx]   <= req.length;
            voice_position[free_idx] <= '0;
          end
        end
        S_SCAN: begin
          // add the sample read for the previous voice
          if (acc_pending) begin
            acc <= acc + SUM_W'(rd_data);
          end
          acc_pending <= cur_active && !cur_expired;
          if (cur_active) begin
            if (cur_expired) begin
              voice_active[vidx]   <= 1'b0;
              voice_position[vidx] <= '0;
              voice_length[vidx]   <= '0;
            end else begin
              voice_position[vidx] <= voice_position[vidx] + LEN_W'(1);
            end
          end
          if (last_voice) begin
            state <= S_FINISH;
          end else begin
            vidx <= vidx + VIDX_W'(1);
          end
        end
        S_FINISH: begin
          acc_pending <= 1'b0;
          state       <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (accept && req.operation != OP_TICK) begin
        out_valid   <= 1'b1;
        out_level   <= '0;
        out_started <= (req.operation == OP_PLAY) && free_found;
        out_slot    <= (req.operation == OP_PLAY && free_found) ? SLOT_W'(free_idx) : '0;
      end else if (state == S_FINISH) begin
        out_valid   <= 1'b1;
        out_level   <= acc_final[MIX_SHIFT +: LEVEL_W] + MIX_OFFSET;
        out_started <= 1'b0;
        out_slot    <= '0;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Checks
  `PVM_ASSERT_NOW(a_scan_out_empty, state == S_SCAN, !out_valid, "result pending during scan")
  `PVM_ASSERT_NEXT(a_finish_loads, state == S_FINISH, out_valid, "tick result not loaded")
  `PVM_ASSERT_NOW(a_pending_in_tick, acc_pending, state != S_IDLE, "stray read")
  `PVM_ASSERT_NEXT(a_expired_freed, scan_expire, !voice_active[$past(vidx)], "voice kept")

endmodule

[tb/pcm_voice_mixer_test.sv]
`timescale 1ns / 1ps

module pcm_voice_mixer_test;
  import pvm_pkg::*;

  localparam op_t     OP_UNUSED   = 2'd3;
  localparam sample_t SAMPLE_MAX  = 16'sh7fff;
  localparam sample_t SAMPLE_MIN  = -16'sh8000;
  localparam int      RANDOM_SEGS = 6;
  localparam int      SEG_ITEMS   = 190;
  localparam int      CYCLE_LIMIT = 3_000_000;
  localparam int      MAX_PRINTS  = 40;
  // written window of the store; it straddles the top address so reads wrap
  localparam int      WIN_BASE    = SAMPLE_DEPTH - 64;
  localparam int      WIN_LEN     = 192;
  localparam int      LONG_TICKS  = 32;

  typedef struct packed {
    level_t dac_level;
    logic   started;
    slot_t  voice_slot;
  } mixer_result_t;

  // Tracks the mixer state and the results still owed by the DUT
  class mixer_scoreboard;
    sample_t       samples[SAMPLE_DEPTH];
    bit            v_active[VOICE_COUNT];
    addr_t         v_start[VOICE_COUNT];
    len_t          v_len[VOICE_COUNT];
    len_t          v_pos[VOICE_COUNT];
    mixer_result_t expected_results[$];
    int error_count, checked_count;
    int tick_count, wrap_count, started_count, dropped_count, write_count, unused_count;

    function new();
      for (int i = 0; i < VOICE_COUNT; i++) begin
        v_active[i] = 1'b0;
        v_start[i]  = '0;
        v_len[i]    = '0;
        v_pos[i]    = '0;
      end
      error_count = 0;
      checked_count = 0;
      tick_count = 0;
      wrap_count = 0;
      started_count = 0;
      dropped_count = 0;
      write_count = 0;
      unused_count = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function bit any_voice_active();
      for (int i = 0; i < VOICE_COUNT; i++)
        if (v_active[i]) return 1'b1;
      return 1'b0;
    endfunction

    // One output sample: walk voices in index order, retire finished ones
    function level_t mix_next_level();
      int sum;
      int q;
      sum = 0;
      for (int i = 0; i < VOICE_COUNT; i++) begin
        if (v_active[i]) begin
          if (v_pos[i] >= v_len[i]) begin
            v_active[i] = 1'b0;
            v_pos[i]    = '0;
            v_len[i]    = '0;
          end else begin
            sum += samples[(int'(v_start[i]) + int'(v_pos[i])) % SAMPLE_DEPTH];
            v_pos[i] = v_pos[i] + 1'b1;
          end
        end
      end
      q = (sum >>> MIX_SHIFT) + int'(MIX_OFFSET);
      if (q < 0 || q >= (1 << LEVEL_W)) wrap_count++;
      return level_t'(q);
    endfunction

    // Accepted request: update state, queue the result it owes
    function void note_request(op_t op, addr_t addr, len_t len, sample_t val);
      mixer_result_t r;
      bit claimed;
      r = '0;
      claimed = 1'b0;
      case (op)
        OP_TICK: begin
          r.dac_level = mix_next_level();
          tick_count++;
        end
        OP_PLAY: begin
          for (int i = 0; i < VOICE_COUNT; i++) begin
            if (!claimed && !v_active[i]) begin
              claimed      = 1'b1;
              v_active[i]  = 1'b1;
              v_start[i]   = addr;
              v_len[i]     = len;
              v_pos[i]     = '0;
              r.started    = 1'b1;
              r.voice_slot = slot_t'(i);
            end
          end
          if (claimed) started_count++;
          else dropped_count++;
        end
        OP_WRITE: begin
          samples[addr] = val;
          write_count++;
        end
        default: unused_count++;
      endcase
      expected_results.push_back(r);
    endfunction

    task report_mismatch(string what);
      if (error_count < MAX_PRINTS) $display("[%0t] MISMATCH: %s", $realtime, what);
      error_count++;
    endtask

    task check_result(level_t lvl, logic st, slot_t slot);
      mixer_result_t want;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result level=%0d started=%0b slot=%0d",
                                  lvl, st, slot));
        return;
      end
      want = expected_results.pop_front();
      checked_count++;
      if (lvl !== want.dac_level)
        report_mismatch($sformatf("dac_level %0d, expected %0d", lvl, want.dac_level));
      if (st !== want.started)
        report_mismatch($sformatf("started %0b, expected %0b", st, want.started));
      if (slot !== want.voice_slot)
        report_mismatch($sformatf("voice_slot %0d, expected %0d", slot, want.voice_slot));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  int   cycle_count = 0;
  int   burst_left = 0;
  mixer_scoreboard sb;

  pvm_req_if req();
  pvm_rsp_if rsp();

  pcm_voice_mixer DUT (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  always #4 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
      $display("simulation failed");
      $finish;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst === 1'b0 && rsp.valid === 1'b1 && rsp.ready === 1'b1)
      sb.check_result(rsp.dac_level, rsp.started, rsp.voice_slot);
  end

  // Receiver: alternating stall patterns, one ready update per falling edge
  initial begin : result_sink
    int mode;
    int span;
    rsp.ready = 1'b0;
    forever begin
      mode = $urandom_range(3);
      span = (mode == 3) ? $urandom_range(1, 12) : $urandom_range(5, 60);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0: rsp.ready = 1'b1;
          1: rsp.ready = ($urandom_range(1) == 1);
          2: rsp.ready = ($urandom_range(3) == 0);
          default: rsp.ready = 1'b0;
        endcase
      end
    end
  end

  // Drive one request in bursts; entered and left at a falling edge
  task automatic send_request(input op_t op, input addr_t a, input len_t l, input sample_t v);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    req.operation    = op;
    req.address      = a;
    req.length       = l;
    req.sample_value = v;
    req.valid        = 1'b1;
    do @(posedge clk); while (req.ready !== 1'b1);
    sb.note_request(op, a, l, v);
    burst_left--;
    @(negedge clk);
  endtask

  // Sender goes quiet until the DUT has answered everything
  task automatic wait_all_results();
    req.valid = 1'b0;
    burst_left = 0;
    while (sb.pending() > 0) @(negedge clk);
  endtask

  // Tick until every voice has run out
  task automatic drain_voices();
    while (sb.any_voice_active())
      send_request(OP_TICK, addr_t'($urandom), len_t'($urandom), sample_t'($urandom));
  endtask

  task automatic random_request();
    int pick;
    int lp;
    int s;
    int room;
    op_t op;
    addr_t a;
    len_t l;
    sample_t v;
    pick = $urandom_range(99);
    a = addr_t'($urandom);
    l = len_t'($urandom);
    v = sample_t'($urandom);
    if (pick < 45) begin
      op = OP_TICK;
    end else if (pick < 72) begin
      // notes stay inside the written window; mostly short so voices keep turning over
      op = OP_PLAY;
      s = $urandom_range(WIN_LEN - 1);
      room = WIN_LEN - s;
      a = addr_t'(WIN_BASE + s);
      lp = $urandom_range(99);
      if (lp < 80) l = len_t'($urandom_range(0, (room < 24) ? room : 24));
      else l = len_t'($urandom_range(0, room));
    end else if (pick < 96) begin
      op = OP_WRITE;
      lp = $urandom_range(19);
      if (lp == 0) v = SAMPLE_MAX;
      else if (lp == 1) v = SAMPLE_MIN;
    end else begin
      op = OP_UNUSED;
    end
    send_request(op, a, l, v);
  endtask

  initial begin : stimulus
    sample_t fill_val;
    int p;
    sb = new();
    rst              = 1'b1;
    req.valid        = 1'b0;
    req.operation    = OP_TICK;
    req.address      = '0;
    req.length       = '0;
    req.sample_value = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Preload a window of the store across the top address; voices only read inside it
    for (int k = 0; k < WIN_LEN; k++) begin
      p = $urandom_range(19);
      fill_val = (p == 0) ? SAMPLE_MAX : (p == 1) ? SAMPLE_MIN : sample_t'($urandom);
      send_request(OP_WRITE, addr_t'(WIN_BASE + k), len_t'($urandom), fill_val);
    end

    // Directed: field extremes, unused code, zero length
    send_request(OP_WRITE, addr_t'(SAMPLE_DEPTH - 1), '0, SAMPLE_MAX);
    send_request(OP_WRITE, '0, '0, SAMPLE_MIN);
    send_request(OP_WRITE, addr_t'(1), '1, -16'sd1);
    send_request(OP_WRITE, addr_t'(2), '0, '0);
    send_request(OP_UNUSED, '1, '1, '1);
    send_request(OP_PLAY, '1, len_t'(16), '0);         // wraps from the top address to zero
    send_request(OP_PLAY, '1, len_t'(2), '0);
    send_request(OP_PLAY, '0, '0, '0);                 // zero length, freed on next tick
    send_request(OP_TICK, '0, '0, '0);
    send_request(OP_TICK, '1, '1, '1);
    // fill every voice, then one more request that must be dropped
    repeat (VOICE_COUNT - 1) send_request(OP_PLAY, '1, len_t'(3), '0);
    // sums here run past the 10-bit range both ways
    repeat (4) send_request(OP_TICK, '0, '0, '0);
    wait_all_results();
    drain_voices();

    // Random traffic in segments, with a full drain of results between them
    for (int seg = 0; seg < RANDOM_SEGS; seg++) begin
      repeat (SEG_ITEMS) random_request();
      wait_all_results();
      if (seg == RANDOM_SEGS / 2) drain_voices();
    end

    // Lengths at and past the store size; only a few ticks so reads stay in the window
    drain_voices();
    send_request(OP_PLAY, '1, '1, '0);
    send_request(OP_PLAY, '1, len_t'(SAMPLE_DEPTH), '0);
    repeat (LONG_TICKS) send_request(OP_TICK, '0, '0, '0);

    wait_all_results();
    repeat (4 * (VOICE_COUNT + 1)) @(posedge clk);

    $display("covered %0d ticks (%0d wrapped), %0d plays started, %0d dropped, %0d writes,",
             sb.tick_count, sb.wrap_count, sb.started_count, sb.dropped_count,
             sb.write_count);
    $display("%0d unused codes; %0d results checked, %0d mismatches",
             sb.unused_count, sb.checked_count, sb.error_count);
    if (sb.error_count == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
